// ===== src/lom_pkg.sv =====
// Package for the limit order matcher: request and record types, sizes.
// Depends on nothing; used by every module of the block.
package lom_pkg;

  localparam int unsigned EntriesDefault = 32;
  localparam int unsigned PriceBitsDefault = 16;
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic        order_side;
    logic [15:0] limit_price;
    logic [31:0] order_qty;
    logic [31:0] client_id;
  } order_t;

  typedef struct packed {
    logic        record_kind;
    logic [31:0] buyer_id;
    logic [31:0] seller_id;
    logic [31:0] fill_qty;
    logic [15:0] hit_price;
    logic [31:0] trade_seq;
    logic [31:0] left_qty;
    logic        rested;
    logic        book_full;
    logic        last;
  } record_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_PLACE,
    ST_CLOSE
  } eng_state_e;

endpackage

// ===== src/lom_front.sv =====
// Front end: accepts order requests and holds them in a short queue.
// Depends on lom_pkg.
module lom_front import lom_pkg::*; #(
  parameter int unsigned PriceBits = PriceBitsDefault
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  output logic   full_o,
  input  order_t order_i,
  output logic   valid_o,
  input  logic   take_i,
  output order_t order_o
);

  localparam int unsigned PtrBits = $clog2(QueueDepth);

  order_t               mem_q [QueueDepth];
  logic [PtrBits-1:0]   wr_q, rd_q;
  logic [PtrBits:0]     cnt_q;
  logic                 do_push, do_pop;
  order_t               masked;

  assign full_o  = (cnt_q == (PtrBits+1)'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = take_i && valid_o;
  assign order_o = mem_q[rd_q];

  // Classify: trim the limit price to the configured price width.
  always_comb begin
    masked = order_i;
    masked.limit_price = order_i.limit_price & 16'((32'd1 << PriceBits) - 32'd1);
  end

  // Storage for queued requests.
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= masked;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= PtrBits'((wr_q + 1'b1) % QueueDepth);
      if (do_pop) rd_q <= PtrBits'((rd_q + 1'b1) % QueueDepth);
      cnt_q <= cnt_q + (PtrBits+1)'(do_push) - (PtrBits+1)'(do_pop);
    end
  end

endmodule

// ===== src/lom_engine.sv =====
// Matching engine: scans the opposite side one entry a cycle, fills, rests.
// Depends on lom_pkg.
module lom_engine import lom_pkg::*; #(
  parameter int unsigned Entries   = EntriesDefault,
  parameter int unsigned PriceBits = PriceBitsDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    take_o,
  input  order_t  order_i,
  output logic    empty_o,
  input  logic    pop_i,
  output record_t rec_o
);

  localparam int unsigned IdxBits = $clog2(Entries);

  // Books, index 0 bids, 1 asks.
  logic [Entries-1:0] val_q [2];
  logic [PriceBits-1:0] pr_q [2][Entries];
  logic [31:0] rem_q [2][Entries];
  logic [31:0] own_q [2][Entries];
  logic [31:0] arr_q [2][Entries];
  logic [31:0] arrival_q, trade_q;

  eng_state_e state_q, state_d;
  order_t     ord_q;
  logic [31:0] left_q;
  logic [IdxBits:0] scan_q, nfill_q;
  logic        found_q;
  logic [IdxBits-1:0] best_q, slot_q, rd_idx_q;
  logic        slot_ok_q;
  logic        rd_val_q;
  logic [PriceBits-1:0] rd_pr_q, bpr_q;
  logic [31:0] rd_arr_q, rd_rem_q, rd_own_q;
  logic [31:0] bage_q, brem_q, bown_q;
  record_t     out_q;
  logic        out_v_q;

  logic        buying, opp, own;
  logic [IdxBits-1:0] si;
  logic [PriceBits-1:0] lim;
  logic [31:0] age, q;
  logic        rd_en, cmp_en, ok, better;
  record_t     trade_rec, close_rec;

  assign buying = !ord_q.order_side;
  assign opp = buying;
  assign own = !buying;
  assign lim = PriceBits'(ord_q.limit_price);
  assign si = scan_q[IdxBits-1:0];

  // The scan reads one entry a cycle into registers and compares it in the next cycle.
  assign rd_en = (scan_q < (IdxBits+1)'(Entries));
  assign cmp_en = (scan_q != '0);
  assign age = arrival_q - rd_arr_q;
  assign ok = cmp_en && rd_val_q && (buying ? (rd_pr_q <= lim) : (rd_pr_q >= lim));
  assign better = !found_q || (rd_pr_q != bpr_q ? (buying ? rd_pr_q < bpr_q
                                                          : rd_pr_q > bpr_q)
                                                : age > bage_q);
  assign q = (left_q < brem_q) ? left_q : brem_q;

  assign empty_o = !out_v_q;
  assign rec_o = out_q;
  assign take_o = (state_q == ST_IDLE) && valid_i;

  // Trade and closing records for the current order.
  always_comb begin
    trade_rec = '0;
    trade_rec.buyer_id = buying ? ord_q.client_id : bown_q;
    trade_rec.seller_id = buying ? bown_q : ord_q.client_id;
    trade_rec.fill_qty = q;
    trade_rec.hit_price = 16'(bpr_q);
    trade_rec.trade_seq = trade_q + 32'd1;
    close_rec = '0;
    close_rec.record_kind = 1'b1;
    close_rec.left_qty = left_q;
    close_rec.rested = (left_q != '0) && slot_ok_q;
    close_rec.book_full = (left_q != '0) && !slot_ok_q;
    close_rec.last = 1'b1;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (valid_i) state_d = ST_SCAN;
      ST_SCAN: begin
        if (left_q == '0 || nfill_q == (IdxBits+1)'(Entries)) state_d = ST_PLACE;
        else if (scan_q == (IdxBits+1)'(Entries))
          state_d = (found_q || ok) ? ST_FILL : ST_PLACE;
      end
      ST_FILL:  if (!out_v_q) state_d = ST_SCAN;
      ST_PLACE: state_d = ST_CLOSE;
      ST_CLOSE: if (!out_v_q) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      val_q[0] <= '0;
      val_q[1] <= '0;
      arrival_q <= '0;
      trade_q <= '0;
      out_v_q <= 1'b0;
      scan_q <= '0;
      nfill_q <= '0;
      found_q <= 1'b0;
      slot_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_i && out_v_q) out_v_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          scan_q <= '0;
          nfill_q <= '0;
          found_q <= 1'b0;
        end
        ST_SCAN: begin
          if (ok && better) found_q <= 1'b1;
          if (rd_en && !val_q[own][si] && !slot_ok_q) slot_ok_q <= 1'b1;
          scan_q <= (scan_q == (IdxBits+1)'(Entries)) ? '0 : scan_q + 1'b1;
        end
        ST_FILL: if (!out_v_q) begin
          out_v_q <= 1'b1;
          trade_q <= trade_q + 1'b1;
          nfill_q <= nfill_q + 1'b1;
          found_q <= 1'b0;
          if (brem_q == q) val_q[opp][best_q] <= 1'b0;
        end
        ST_PLACE: begin
          // Rest the remainder in the lowest free entry found by the scan.
          if (left_q != '0 && slot_ok_q) begin
            val_q[own][slot_q] <= 1'b1;
            arrival_q <= arrival_q + 1'b1;
          end
        end
        ST_CLOSE: if (!out_v_q) begin
          out_v_q <= 1'b1;
          slot_ok_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Payload registers and book storage.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (valid_i) begin
        ord_q <= order_i;
        left_q <= order_i.order_qty;
      end
      ST_SCAN: begin
        if (rd_en) begin
          rd_idx_q <= si;
          rd_val_q <= val_q[opp][si];
          rd_pr_q <= pr_q[opp][si];
          rd_arr_q <= arr_q[opp][si];
          rd_rem_q <= rem_q[opp][si];
          rd_own_q <= own_q[opp][si];
        end
        if (ok && better) begin
          best_q <= rd_idx_q;
          bpr_q <= rd_pr_q;
          bage_q <= age;
          brem_q <= rd_rem_q;
          bown_q <= rd_own_q;
        end
        // The scan runs from index zero up, so the first free entry is the lowest.
        if (rd_en && !val_q[own][si] && !slot_ok_q) slot_q <= si;
      end
      ST_FILL: if (!out_v_q) begin
        out_q <= trade_rec;
        left_q <= left_q - q;
        rem_q[opp][best_q] <= brem_q - q;
      end
      ST_PLACE: if (left_q != '0 && slot_ok_q) begin
        pr_q[own][slot_q] <= lim;
        rem_q[own][slot_q] <= left_q;
        own_q[own][slot_q] <= ord_q.client_id;
        arr_q[own][slot_q] <= arrival_q;
      end
      ST_CLOSE: if (!out_v_q) begin
        out_q <= close_rec;
      end
      default: ;
    endcase
  end

endmodule

// ===== src/limit_order_matcher.sv =====
// Top level of the limit order matcher: front queue plus matching engine.
// Depends on lom_pkg, lom_front and lom_engine.
//
// Usage: push an order request on order_i when full is low. Records come
// out in order on rec_o while empty is low; pop takes one. Each order
// yields zero or more trade records and then one closing record (last set).
// A scan pass reads one book entry per cycle, registers it and compares the
// registered copy, and every fill needs a full scan pass over the book.
// The engine's single-entry scan sets how fast orders are matched. A
// two-deep queue in front takes new orders while the engine works.
// When the receiver stalls, the engine holds its next record and waits.
// Reset empties both sides of the book and clears the trade and arrival
// counters; no clearing pass is needed.
module limit_order_matcher import lom_pkg::*; #(
  parameter int unsigned Entries   = EntriesDefault,
  parameter int unsigned PriceBits = PriceBitsDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push,
  output logic    full,
  input  order_t  order_i,
  output logic    empty,
  input  logic    pop,
  output record_t rec_o
);

  logic   q_valid, q_take;
  order_t q_order;

  lom_front #(.PriceBits(PriceBits)) u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .order_i,
    .valid_o(q_valid), .take_i(q_take), .order_o(q_order)
  );

  lom_engine #(.Entries(Entries), .PriceBits(PriceBits)) u_engine (
    .clk_i, .rst_ni, .valid_i(q_valid), .take_o(q_take), .order_i(q_order),
    .empty_o(empty), .pop_i(pop), .rec_o
  );

  // A record that waits must hold until it is popped.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(rec_o)))
    else $error("waiting record changed");

  // A closing record always carries the last flag, a trade never does.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (rec_o.last == rec_o.record_kind))
    else $error("last flag mismatch");

  // Rested and book full never appear together.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(rec_o.rested && rec_o.book_full))
    else $error("rested and book_full both set");

endmodule

// ===== tb/tb.sv =====
// Testbench for the limit order matcher: drives order requests, predicts
// trade and closing records with its own book, and checks them in order.
// Depends on lom_pkg and limit_order_matcher.
`timescale 1ns / 100ps

module tb;
  import lom_pkg::*;

  localparam int unsigned NumEntries = 32;
  localparam int unsigned WatchLimit = 20000;

  logic    clk_i;
  logic    rst_ni;
  logic    push;
  logic    full;
  order_t  order_i;
  logic    empty;
  logic    pop;
  record_t rec_o;

  limit_order_matcher u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .order_i(order_i),
    .empty  (empty),
    .pop    (pop),
    .rec_o  (rec_o)
  );

  // Predicted book state.
  logic        bk_valid   [2][NumEntries];
  logic [15:0] bk_price   [2][NumEntries];
  logic [31:0] bk_left    [2][NumEntries];
  logic [31:0] bk_owner   [2][NumEntries];
  logic [31:0] bk_arrival [2][NumEntries];
  logic [31:0] arrivals;
  logic [31:0] trades;

  order_t  pending_orders[$];
  record_t expected_records[$];
  int      errors;
  int      send_idle;   // percent of cycles the sender idles
  int      recv_idle;   // percent of cycles the receiver stalls
  int      hold_off;    // cycles of forced receiver stall left
  bit      hold_go;
  bit      hold_done;
  int      quiet;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Matches one order against the predicted book and queues its records.
  function automatic void match_order(order_t ord);
    int          opp;
    int          own;
    int          best;
    int          fills;
    int          slot;
    logic [31:0] remain;
    logic [31:0] q;
    logic [31:0] age;
    logic [31:0] best_age;
    logic [15:0] best_pr;
    logic        better;
    logic        buying;
    record_t     r;
    buying = (ord.order_side == 1'b0);
    opp = buying ? 1 : 0;
    own = buying ? 0 : 1;
    remain = ord.order_qty;
    fills = 0;
    while (remain != 0 && fills < NumEntries) begin
      best = -1;
      best_age = '0;
      best_pr = '0;
      for (int i = 0; i < NumEntries; i++) begin
        if (bk_valid[opp][i] &&
            (buying ? bk_price[opp][i] <= ord.limit_price
                    : bk_price[opp][i] >= ord.limit_price)) begin
          age = arrivals - bk_arrival[opp][i];
          if (best < 0) better = 1'b1;
          else if (bk_price[opp][i] != best_pr)
            better = buying ? (bk_price[opp][i] < best_pr) : (bk_price[opp][i] > best_pr);
          else better = (age > best_age);
          if (better) begin
            best = i;
            best_pr = bk_price[opp][i];
            best_age = age;
          end
        end
      end
      if (best < 0) break;
      q = (remain < bk_left[opp][best]) ? remain : bk_left[opp][best];
      trades = trades + 32'd1;
      r = '0;
      r.buyer_id = buying ? ord.client_id : bk_owner[opp][best];
      r.seller_id = buying ? bk_owner[opp][best] : ord.client_id;
      r.fill_qty = q;
      r.hit_price = bk_price[opp][best];
      r.trade_seq = trades;
      expected_records.push_back(r);
      fills++;
      remain = remain - q;
      bk_left[opp][best] = bk_left[opp][best] - q;
      if (bk_left[opp][best] == 0) bk_valid[opp][best] = 1'b0;
    end
    r = '0;
    r.record_kind = 1'b1;
    r.last = 1'b1;
    r.left_qty = remain;
    if (remain != 0) begin
      slot = -1;
      for (int i = 0; i < NumEntries; i++) begin
        if (slot < 0 && !bk_valid[own][i]) slot = i;
      end
      if (slot < 0) begin
        r.book_full = 1'b1;
      end else begin
        bk_valid[own][slot] = 1'b1;
        bk_price[own][slot] = ord.limit_price;
        bk_left[own][slot] = remain;
        bk_owner[own][slot] = ord.client_id;
        bk_arrival[own][slot] = arrivals;
        arrivals = arrivals + 32'd1;
        r.rested = 1'b1;
      end
    end
    expected_records.push_back(r);
  endfunction

  function automatic order_t make_order(logic side, logic [15:0] pr, logic [31:0] qty);
    order_t o;
    o.order_side = side;
    o.limit_price = pr;
    o.order_qty = qty;
    o.client_id = $urandom;
    return o;
  endfunction

  // Driver: offers the head of the pending queue.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
      order_i <= '0;
    end else begin
      if (push && !full) begin
        match_order(order_i);
        pending_orders.delete(0);
      end
      if ((!push || !full) ? 1'b1 : 1'b0) begin
        if (pending_orders.size() > (push && !full ? 0 : 0) &&
            ($urandom_range(99) >= send_idle)) begin
          push <= 1'b1;
          order_i <= pending_orders[0];
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: pops records at random and checks them in order.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
      quiet <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_records.size() == 0) begin
          $display("%0t: unexpected record %p", $time, rec_o);
          errors++;
        end else begin
          if (rec_o !== expected_records[0]) begin
            $display("%0t: record mismatch expected %p actual %p", $time,
                     expected_records[0], rec_o);
            errors++;
          end
          expected_records.delete(0);
        end
      end
      if ((pop && !empty) || (push && !full)) quiet <= 0;
      else quiet <= quiet + 1;
      if (hold_off > 0) begin
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Receiver hold-off: one long stall while the sender keeps offering.
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end else if (hold_go && !hold_done) begin
      hold_off <= 400;
      hold_done <= 1'b1;
    end
  end

  // Watchdog on cycles without any accepted request or record.
  always @(posedge clk_i) begin
    if (quiet >= WatchLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic drain();
    while (pending_orders.size() != 0 || expected_records.size() != 0 || push)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic random_phase(int count, int s_idle, int r_idle);
    logic [15:0] pr;
    logic [31:0] qty;
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int i = 0; i < count; i++) begin
      // Prices near a center so that bids and asks cross often.
      pr = 16'd1000 + 16'($urandom_range(20)) - 16'd10;
      case ($urandom_range(9))
        0: pr = 16'($urandom);
        1: pr = ($urandom_range(1)) ? 16'hFFFF : 16'h0000;
        default: ;
      endcase
      qty = 32'($urandom_range(1, 20));
      case ($urandom_range(9))
        0: qty = $urandom;
        1: qty = 32'd0;
        2: qty = ($urandom_range(1)) ? 32'hFFFF_FFFF : 32'd1;
        default: ;
      endcase
      pending_orders.push_back(make_order(1'($urandom_range(1)), pr, qty));
    end
    drain();
  endtask

  initial begin
    for (int s = 0; s < 2; s++) begin
      for (int i = 0; i < NumEntries; i++) bk_valid[s][i] = 1'b0;
    end
    arrivals = '0;
    trades = '0;
    errors = 0;
    send_idle = 0;
    recv_idle = 0;
    hold_go = 1'b0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero quantity, extreme prices and quantities, time priority,
    // partial fills, sweep across several levels.
    pending_orders.push_back(make_order(1'b0, 16'd100, 32'd0));
    pending_orders.push_back(make_order(1'b1, 16'hFFFF, 32'hFFFF_FFFF));
    pending_orders.push_back(make_order(1'b0, 16'h0000, 32'd5));
    pending_orders.push_back(make_order(1'b0, 16'hFFFF, 32'd3));
    pending_orders.push_back(make_order(1'b1, 16'd50, 32'd4));
    pending_orders.push_back(make_order(1'b1, 16'd50, 32'd4));
    pending_orders.push_back(make_order(1'b1, 16'd40, 32'd2));
    pending_orders.push_back(make_order(1'b0, 16'd60, 32'd7));
    pending_orders.push_back(make_order(1'b0, 16'd60, 32'd10));
    pending_orders.push_back(make_order(1'b1, 16'h0000, 32'd100));
    pending_orders.push_back(make_order(1'b0, 16'hFFFF, 32'hFFFF_FFFF));
    pending_orders.push_back(make_order(1'b1, 16'h0000, 32'hFFFF_FFFF));
    drain();

    // Fill the ask side past capacity so remainders are dropped.
    for (int i = 0; i < NumEntries + 3; i++)
      pending_orders.push_back(make_order(1'b1, 16'd2000 + 16'(i), 32'd1));
    pending_orders.push_back(make_order(1'b0, 16'hFFFF, 32'd40));
    drain();

    // Long receiver hold-off while orders keep coming, so the input stalls.
    hold_go = 1'b1;
    random_phase(12, 0, 0);
    random_phase(10, 0, 0);
    random_phase(10, 77, 0);
    random_phase(10, 0, 77);
    random_phase(10, 37, 37);

    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
